[src/nlp_pkg.sv]
// Shared types, codes and a character helper for the numeric literal parser.
package nlp_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int OUT_BITS    = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] FMT_HEX_PREFIX = 2'd0;
	localparam logic [1:0] FMT_HEX_SUFFIX = 2'd1;
	localparam logic [1:0] FMT_BINARY     = 2'd2;
	localparam logic [1:0] FMT_DECIMAL    = 2'd3;

	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_HEX  = 2'd1;
	localparam logic [1:0] PFX_BIN  = 2'd2;

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_UPPER_B = 8'h42;
	localparam logic [7:0] CH_LOWER_H = 8'h68;
	localparam logic [7:0] CH_UPPER_H = 8'h48;

	// One classified character, as passed from the front to the back.
	typedef struct packed {
		logic       last;
		logic       is_h;
		logic       hex_ok;
		logic       bin_ok;
		logic       dec_ok;
		logic       pos_ge2;
		logic       hex_restart;
		logic [1:0] prefix;
		logic [3:0] digit;
	} class_t;

	// Returns {valid, nibble} for a hex digit character.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[CH_0:CH_9]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

[src/nlp_front.sv]
// Front end: accepts characters, tracks position and prefix, classifies each beat.
module nlp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       char_code,
	input  logic             last_char,
	input  logic             char_valid,
	output logic             char_ready,
	output logic             push_valid,
	input  logic             push_ready,
	output nlp_pkg::class_t  push_data
);

	logic [1:0] pos_q;
	logic       first_zero_q;
	logic [1:0] prefix_q;
	logic       first_zero_n;
	logic [1:0] prefix_n;
	logic [4:0] hd;
	logic       take;

	assign char_ready = push_ready;
	assign push_valid = char_valid;
	assign take       = char_valid && push_ready;
	assign hd         = nlp_pkg::hex_digit(char_code);

	always_comb begin
		first_zero_n = first_zero_q;
		prefix_n     = prefix_q;
		case (pos_q)
			2'd0: begin
				first_zero_n = (char_code == nlp_pkg::CH_0);
				prefix_n     = nlp_pkg::PFX_NONE;
			end
			2'd1: begin
				if (first_zero_q && (char_code == nlp_pkg::CH_LOWER_X ||
						char_code == nlp_pkg::CH_UPPER_X)) begin
					prefix_n = nlp_pkg::PFX_HEX;
				end else if (first_zero_q && (char_code == nlp_pkg::CH_LOWER_B ||
						char_code == nlp_pkg::CH_UPPER_B)) begin
					prefix_n = nlp_pkg::PFX_BIN;
				end else begin
					prefix_n = nlp_pkg::PFX_NONE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		push_data.last        = last_char;
		push_data.is_h        = (char_code == nlp_pkg::CH_LOWER_H ||
			char_code == nlp_pkg::CH_UPPER_H);
		push_data.hex_ok      = hd[4];
		push_data.bin_ok      = (char_code == nlp_pkg::CH_0 || char_code == nlp_pkg::CH_1);
		push_data.dec_ok      = (char_code inside {[nlp_pkg::CH_0:nlp_pkg::CH_9]});
		push_data.pos_ge2     = (pos_q == 2'd2);
		push_data.hex_restart = (pos_q == 2'd1) && (prefix_n == nlp_pkg::PFX_HEX);
		push_data.prefix      = prefix_n;
		push_data.digit       = hd[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 2'd0;
			first_zero_q <= 1'b0;
			prefix_q     <= nlp_pkg::PFX_NONE;
		end else if (take) begin
			if (last_char) begin
				pos_q        <= 2'd0;
				first_zero_q <= 1'b0;
				prefix_q     <= nlp_pkg::PFX_NONE;
			end else begin
				// advance position, saturate at two
				if (pos_q != 2'd2) begin
					pos_q <= pos_q + 2'd1;
				end
				first_zero_q <= first_zero_n;
				prefix_q     <= prefix_n;
			end
		end
	end

endmodule

[src/nlp_queue.sv]
// Short queue of classified beats between front and back.
module nlp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  nlp_pkg::class_t  push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output nlp_pkg::class_t  pop_data
);

	nlp_pkg::class_t                 mem_q [nlp_pkg::QUEUE_DEPTH];
	logic [nlp_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [nlp_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [nlp_pkg::QCNT_BITS-1:0]   count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != nlp_pkg::QCNT_BITS'(nlp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/nlp_back.sv]
// Back end: runs the hex, binary and decimal scans and registers each result.
module nlp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  nlp_pkg::class_t  pop_data,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [nlp_pkg::OUT_BITS-1:0] value,
	output logic [1:0]       format,
	output logic             bad_format
);

	localparam int VB = nlp_pkg::VALUE_BITS;

	logic [VB-1:0] hex_acc_q, hex_acc_n;
	logic          hex_stop_q, hex_stop_n;
	logic          hex_seen_q, hex_seen_n;
	logic [VB-1:0] bin_acc_q, bin_acc_n;
	logic          bin_bad_q, bin_bad_n;
	logic [VB-1:0] dec_acc_q, dec_acc_n;
	logic          dec_bad_q, dec_bad_n;
	logic [VB-1:0] prev_q;
	logic [VB-1:0] res_value;
	logic [1:0]    res_fmt;
	logic          res_bad;
	logic          out_valid_q;
	logic [nlp_pkg::OUT_BITS-1:0] value_q;
	logic [1:0]    format_q;
	logic          bad_q;
	logic          out_free;
	logic          pop;

	assign out_free  = !out_valid_q || result_ready;
	// a closing beat waits only for room in the output register
	assign pop_ready = !pop_data.last || out_free;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		hex_acc_n  = hex_acc_q;
		hex_stop_n = hex_stop_q;
		hex_seen_n = hex_seen_q;
		if (pop_data.hex_restart) begin
			hex_acc_n  = '0;
			hex_stop_n = 1'b0;
			hex_seen_n = 1'b0;
		end else if (!hex_stop_q) begin
			if (pop_data.hex_ok) begin
				hex_acc_n  = {hex_acc_q[VB-5:0], pop_data.digit};
				hex_seen_n = 1'b1;
			end else begin
				hex_stop_n = 1'b1;
			end
		end

		bin_acc_n = bin_acc_q;
		bin_bad_n = bin_bad_q;
		if (pop_data.pos_ge2 && !bin_bad_q) begin
			if (pop_data.bin_ok) begin
				bin_acc_n = {bin_acc_q[VB-2:0], pop_data.digit[0]};
			end else begin
				bin_bad_n = 1'b1;
			end
		end

		dec_acc_n = dec_acc_q;
		dec_bad_n = dec_bad_q;
		if (!dec_bad_q) begin
			if (pop_data.dec_ok) begin
				// times ten as two shifts and an add
				dec_acc_n = {dec_acc_q[VB-4:0], 3'b000} + {dec_acc_q[VB-2:0], 1'b0}
					+ VB'(pop_data.digit);
			end else begin
				dec_bad_n = 1'b1;
			end
		end
	end

	always_comb begin
		res_bad = 1'b0;
		if (pop_data.prefix == nlp_pkg::PFX_HEX) begin
			res_value = hex_acc_n;
			res_fmt   = nlp_pkg::FMT_HEX_PREFIX;
		end else if (pop_data.is_h) begin
			res_value = hex_seen_q ? hex_acc_q : prev_q;
			res_fmt   = nlp_pkg::FMT_HEX_SUFFIX;
		end else if (pop_data.prefix == nlp_pkg::PFX_BIN) begin
			res_value = bin_acc_n;
			res_fmt   = nlp_pkg::FMT_BINARY;
			res_bad   = bin_bad_n;
		end else begin
			res_value = dec_acc_n;
			res_fmt   = nlp_pkg::FMT_DECIMAL;
			res_bad   = dec_bad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_acc_q   <= '0;
			hex_stop_q  <= 1'b0;
			hex_seen_q  <= 1'b0;
			bin_acc_q   <= '0;
			bin_bad_q   <= 1'b0;
			dec_acc_q   <= '0;
			dec_bad_q   <= 1'b0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_data.last) begin
					// drop the token state, keep the value for a bare suffix
					hex_acc_q   <= '0;
					hex_stop_q  <= 1'b0;
					hex_seen_q  <= 1'b0;
					bin_acc_q   <= '0;
					bin_bad_q   <= 1'b0;
					dec_acc_q   <= '0;
					dec_bad_q   <= 1'b0;
					prev_q      <= res_value;
					out_valid_q <= 1'b1;
				end else begin
					hex_acc_q  <= hex_acc_n;
					hex_stop_q <= hex_stop_n;
					hex_seen_q <= hex_seen_n;
					bin_acc_q  <= bin_acc_n;
					bin_bad_q  <= bin_bad_n;
					dec_acc_q  <= dec_acc_n;
					dec_bad_q  <= dec_bad_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.last) begin
			value_q  <= nlp_pkg::OUT_BITS'(res_value);
			format_q <= res_fmt;
			bad_q    <= res_bad;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign format       = format_q;
	assign bad_format   = bad_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_data.last |=> out_valid_q)
		else $error("closing beat did not load the output register");

	a_token_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_data.last |=> !hex_seen_q && !hex_stop_q && !bin_bad_q && !dec_bad_q
			&& hex_acc_q == '0 && bin_acc_q == '0 && dec_acc_q == '0)
		else $error("token state not cleared after a result");

	a_hex_never_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (format_q == nlp_pkg::FMT_HEX_PREFIX ||
			format_q == nlp_pkg::FMT_HEX_SUFFIX) |-> !bad_q)
		else $error("hex result flagged bad");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ready |-> !(pop && pop_data.last))
		else $error("pending result overwritten");

endmodule

[src/number_literal_parser_top.sv]
// Top level of the numeric literal parser: front, beat queue, back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  char     | char_valid / char_ready    | char_code, last_char
//  result   | result_valid / result_ready| value, format, bad_format
//
// One character per cycle while the queue has room; the queue registers each beat
// and the back registers the result of its closing beat.
// The four-entry queue and the output register set the slack between sides:
// a closing beat waits out a stalled result; the front takes beats until the
// queue fills. Reset clears all token state and the remembered previous value.
module number_literal_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	input  logic        char_valid,
	output logic        char_ready,
	output logic [31:0] value,
	output logic [1:0]  format,
	output logic        bad_format,
	output logic        result_valid,
	input  logic        result_ready
);

	logic            push_valid;
	logic            push_ready;
	nlp_pkg::class_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	nlp_pkg::class_t pop_data;

	nlp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	nlp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	nlp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.format       (format),
		.bad_format   (bad_format)
	);

endmodule
